@@ hdl/bbc_pkg.sv @@
`timescale 1ns / 1ps

package bbc_pkg;

    // Field widths of the request and response transactions.
    localparam int ACT_W  = 2;
    localparam int DEV_W  = 16;
    localparam int BLK_W  = 32;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 8;
    localparam int TAG_W  = DEV_W + BLK_W;

    // Default number of buffers tracked by the engine.
    localparam int DEFAULT_BUFFER_COUNT = 32;

    // Largest reference count a buffer can hold.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request actions.
    localparam logic [ACT_W-1:0] ACT_GET     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PIN     = 2'd2;

    // Response status codes.
    localparam logic [STAT_W-1:0] STAT_HIT   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NEW   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EVICT = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NONE  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ERR   = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;

    // One request transaction.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [DEV_W-1:0] device;
        logic [BLK_W-1:0] block_number;
        t_idx             buffer_index;
    } t_req;

    // One response transaction.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_idx              granted_index;
        logic              needs_fill;
        logic [CNT_W-1:0]  new_count;
    } t_result;

endpackage

@@ hdl/block_buffer_cache_tags.sv @@
`timescale 1ns / 1ps

// Tag and reference-count engine of a disk block buffer cache.
// Requests arrive on the i_valid / o_ready channel (action, device, block number,
// buffer index); each request yields exactly one response transaction on the
// o_valid / i_ready channel (status, granted index, fill request, new count).
// A get scans every buffer once through a single tag comparator, reading one
// tag from the tag RAM per cycle, and then decides and writes back.
// Release, pin and unknown actions read one count and change at most that one;
// no request is taken before the last one's response has been passed on.
// o_ready is high only while the sequencer is idle.
// The response sits in an output register, so the next request is taken while
// a finished response still waits; if the receiver stalls longer, the engine
// holds its next response and stops taking requests until the register frees.
// Reset clears all reference counts and allocation bits at once; tags of
// unused buffers are read but ignored, so no clearing pass is needed.
module block_buffer_cache_tags #(
    parameter int BUFFER_COUNT = bbc_pkg::DEFAULT_BUFFER_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bbc_pkg::ACT_W-1:0]  i_action,
    input  logic [bbc_pkg::DEV_W-1:0]  i_device,
    input  logic [bbc_pkg::BLK_W-1:0]  i_block_number,
    input  logic [bbc_pkg::IDX_W-1:0]  i_buffer_index,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bbc_pkg::STAT_W-1:0] o_status,
    output logic [bbc_pkg::IDX_W-1:0]  o_granted_index,
    output logic                       o_needs_fill,
    output logic [bbc_pkg::CNT_W-1:0]  o_new_count
);

    localparam int AW = $clog2(BUFFER_COUNT);

    bbc_pkg::t_req             req;
    bbc_pkg::t_result          res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      tag_wr_en;
    logic [AW-1:0]             tag_wr_addr;
    logic [bbc_pkg::TAG_W-1:0] tag_wr_data;
    logic [AW-1:0]             tag_rd_addr;
    logic [bbc_pkg::TAG_W-1:0] tag_rd_data;

    logic             r_o_valid;
    bbc_pkg::t_result r_o;

    // Gather the request fields.
    always_comb begin
        req.action       = i_action;
        req.device       = i_device;
        req.block_number = i_block_number;
        req.buffer_index = i_buffer_index;
    end

    bbc_engine #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .o_req_ready   (o_ready),
        .i_req         (req),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res),
        .o_tag_wr_en   (tag_wr_en),
        .o_tag_wr_addr (tag_wr_addr),
        .o_tag_wr_data (tag_wr_data),
        .o_tag_rd_addr (tag_rd_addr),
        .i_tag_rd_data (tag_rd_data)
    );

    bbc_tag_ram #(
        .DEPTH (BUFFER_COUNT)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_wr_en),
        .i_wr_addr (tag_wr_addr),
        .i_wr_data (tag_wr_data),
        .i_rd_addr (tag_rd_addr),
        .o_rd_data (tag_rd_data)
    );

    // Output register: loads when empty or when the receiver takes its content.
    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_o <= res;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o.status;
    assign o_granted_index = r_o.granted_index;
    assign o_needs_fill    = r_o.needs_fill;
    assign o_new_count     = r_o.new_count;

endmodule

@@ hdl/bbc_tag_ram.sv @@
`timescale 1ns / 1ps

module bbc_tag_ram #(
    parameter int  DEPTH = bbc_pkg::DEFAULT_BUFFER_COUNT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [bbc_pkg::TAG_W-1:0] i_wr_data,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [bbc_pkg::TAG_W-1:0] o_rd_data
);

    // Device and block tag of each buffer; one write and one registered read port.
    logic [bbc_pkg::TAG_W-1:0] r_mem [DEPTH];
    logic [bbc_pkg::TAG_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/bbc_engine.sv @@
`timescale 1ns / 1ps

module bbc_engine #(
    parameter int  BUFFER_COUNT = bbc_pkg::DEFAULT_BUFFER_COUNT,
    localparam int AW           = $clog2(BUFFER_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  bbc_pkg::t_req             i_req,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output bbc_pkg::t_result          o_res,
    output logic                      o_tag_wr_en,
    output logic [AW-1:0]             o_tag_wr_addr,
    output logic [bbc_pkg::TAG_W-1:0] o_tag_wr_data,
    output logic [AW-1:0]             o_tag_rd_addr,
    input  logic [bbc_pkg::TAG_W-1:0] i_tag_rd_data
);

    localparam int CW = $clog2(BUFFER_COUNT + 1);
    localparam logic [CW-1:0] LAST = CW'(BUFFER_COUNT);
    localparam logic [bbc_pkg::IDX_W:0] LIMIT = (bbc_pkg::IDX_W + 1)'(BUFFER_COUNT);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    // Control state.
    logic [2:0] r_state, n_state;
    logic       r_pend, n_pend;
    logic       r_hit_f, n_hit_f;
    logic       r_unused_f, n_unused_f;
    logic       r_zero_f, n_zero_f;
    logic [BUFFER_COUNT-1:0]   r_used;
    logic [bbc_pkg::CNT_W-1:0] r_ref [BUFFER_COUNT];

    // Payload state.
    bbc_pkg::t_req             r_req, n_req;
    bbc_pkg::t_result          r_res, n_res;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [AW-1:0]             r_idx_d, n_idx_d;
    logic [AW-1:0]             r_hit_i, n_hit_i;
    logic [AW-1:0]             r_unused_i, n_unused_i;
    logic [AW-1:0]             r_zero_i, n_zero_i;
    logic [bbc_pkg::CNT_W-1:0] r_hit_cnt, n_hit_cnt;

    // Count and used-bit write port.
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [bbc_pkg::CNT_W-1:0] wr_cnt;
    logic                      set_used;

    // Count and used-bit read port and the shared tag comparator.
    logic [AW-1:0]             rd_addr;
    logic [bbc_pkg::CNT_W-1:0] rd_cnt;
    logic                      rd_used;
    logic                      tag_match;
    logic                      in_range;

    assign rd_addr   = (r_state == S_SCAN) ? r_idx_d : r_req.buffer_index[AW-1:0];
    assign rd_cnt    = r_ref[rd_addr];
    assign rd_used   = r_used[rd_addr];
    assign tag_match = (i_tag_rd_data == {r_req.device, r_req.block_number});
    assign in_range  = ({1'b0, r_req.buffer_index} < LIMIT);

    // Sequencer: a get scans one buffer per cycle, then decides, writes back.
    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_hit_f    = r_hit_f;
        n_unused_f = r_unused_f;
        n_zero_f   = r_zero_f;
        n_req      = r_req;
        n_res      = r_res;
        n_cnt      = r_cnt;
        n_idx_d    = r_idx_d;
        n_hit_i    = r_hit_i;
        n_unused_i = r_unused_i;
        n_zero_i   = r_zero_i;
        n_hit_cnt  = r_hit_cnt;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_cnt     = '0;
        set_used   = 1'b0;
        o_tag_wr_en   = 1'b0;
        o_tag_wr_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req      = i_req;
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                    n_hit_f    = 1'b0;
                    n_unused_f = 1'b0;
                    n_zero_f   = 1'b0;
                    n_state    = (i_req.action == bbc_pkg::ACT_GET) ? S_SCAN : S_UPD;
                end
            end

            S_SCAN: begin
                // Issue the next tag read; the data returns in the next cycle.
                n_pend  = (r_cnt < LAST);
                n_idx_d = r_cnt[AW-1:0];
                if (r_cnt < LAST) begin
                    n_cnt = r_cnt + CW'(1);
                end
                // Examine the buffer whose tag has just come back.
                if (r_pend) begin
                    if (rd_used) begin
                        if (!r_hit_f && tag_match) begin
                            n_hit_f   = 1'b1;
                            n_hit_i   = r_idx_d;
                            n_hit_cnt = rd_cnt;
                        end
                        if (!r_zero_f && (rd_cnt == '0)) begin
                            n_zero_f = 1'b1;
                            n_zero_i = r_idx_d;
                        end
                    end else if (!r_unused_f) begin
                        n_unused_f = 1'b1;
                        n_unused_i = r_idx_d;
                    end
                end
                if (r_cnt == LAST) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_res.needs_fill = 1'b0;
                if (r_hit_f) begin
                    n_res.granted_index = bbc_pkg::t_idx'(r_hit_i);
                    if (r_hit_cnt == bbc_pkg::CNT_MAX) begin
                        n_res.status    = bbc_pkg::STAT_ERR;
                        n_res.new_count = bbc_pkg::CNT_MAX;
                    end else begin
                        wr_en           = 1'b1;
                        wr_addr         = r_hit_i;
                        wr_cnt          = r_hit_cnt + 8'd1;
                        n_res.status    = bbc_pkg::STAT_HIT;
                        n_res.new_count = r_hit_cnt + 8'd1;
                    end
                end else if (r_unused_f || r_zero_f) begin
                    // Allocate a fresh buffer if any is left, else evict.
                    wr_en         = 1'b1;
                    wr_addr       = r_unused_f ? r_unused_i : r_zero_i;
                    wr_cnt        = 8'd1;
                    set_used      = r_unused_f;
                    o_tag_wr_en   = 1'b1;
                    o_tag_wr_addr = wr_addr;
                    n_res.status  = r_unused_f ? bbc_pkg::STAT_NEW : bbc_pkg::STAT_EVICT;
                    n_res.granted_index = bbc_pkg::t_idx'(wr_addr);
                    n_res.needs_fill    = 1'b1;
                    n_res.new_count     = 8'd1;
                end else begin
                    n_res.status        = bbc_pkg::STAT_NONE;
                    n_res.granted_index = '0;
                    n_res.new_count     = '0;
                end
                n_state = S_RESP;
            end

            S_UPD: begin
                n_res.status        = bbc_pkg::STAT_ERR;
                n_res.granted_index = r_req.buffer_index;
                n_res.needs_fill    = 1'b0;
                n_res.new_count     = '0;
                if (in_range) begin
                    case (r_req.action)
                        bbc_pkg::ACT_RELEASE: begin
                            if (rd_cnt != '0) begin
                                wr_en           = 1'b1;
                                wr_addr         = r_req.buffer_index[AW-1:0];
                                wr_cnt          = rd_cnt - 8'd1;
                                n_res.status    = bbc_pkg::STAT_HIT;
                                n_res.new_count = rd_cnt - 8'd1;
                            end
                        end
                        bbc_pkg::ACT_PIN: begin
                            if (rd_cnt == bbc_pkg::CNT_MAX) begin
                                n_res.new_count = bbc_pkg::CNT_MAX;
                            end else begin
                                wr_en           = 1'b1;
                                wr_addr         = r_req.buffer_index[AW-1:0];
                                wr_cnt          = rd_cnt + 8'd1;
                                n_res.status    = bbc_pkg::STAT_HIT;
                                n_res.new_count = rd_cnt + 8'd1;
                            end
                        end
                        default: begin
                            // Unknown action: report the count untouched.
                            n_res.new_count = rd_cnt;
                        end
                    endcase
                end
                n_state = S_RESP;
            end

            S_RESP: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers, counts and used bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend     <= 1'b0;
            r_hit_f    <= 1'b0;
            r_unused_f <= 1'b0;
            r_zero_f   <= 1'b0;
            r_used     <= '0;
            for (int i = 0; i < BUFFER_COUNT; i++) begin
                r_ref[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_pend     <= n_pend;
            r_hit_f    <= n_hit_f;
            r_unused_f <= n_unused_f;
            r_zero_f   <= n_zero_f;
            if (wr_en) begin
                r_ref[wr_addr] <= wr_cnt;
            end
            if (set_used) begin
                r_used[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_cnt      <= n_cnt;
        r_idx_d    <= n_idx_d;
        r_hit_i    <= n_hit_i;
        r_unused_i <= n_unused_i;
        r_zero_i   <= n_zero_i;
        r_hit_cnt  <= n_hit_cnt;
    end

    assign o_req_ready   = (r_state == S_IDLE);
    assign o_res_valid   = (r_state == S_RESP);
    assign o_res         = r_res;
    assign o_tag_wr_data = {r_req.device, r_req.block_number};
    assign o_tag_rd_addr = r_cnt[AW-1:0];

endmodule

@@ hdl/bbc_checker.sv @@
`timescale 1ns / 1ps

module bbc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic [bbc_pkg::ACT_W-1:0]  i_action,
    input logic [bbc_pkg::DEV_W-1:0]  i_device,
    input logic [bbc_pkg::BLK_W-1:0]  i_block_number,
    input logic [bbc_pkg::IDX_W-1:0]  i_buffer_index,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [bbc_pkg::STAT_W-1:0] o_status,
    input logic [bbc_pkg::IDX_W-1:0]  o_granted_index,
    input logic                       o_needs_fill,
    input logic [bbc_pkg::CNT_W-1:0]  o_new_count
);

    // A stalled response holds its status, index and count.
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_granted_index) && $stable(o_new_count))
        else $error("response changed while stalled");

    // The engine works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while busy");

    // Every miss that allocates asks for a fill and starts at count one.
    a_miss_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bbc_pkg::STAT_NEW || o_status == bbc_pkg::STAT_EVICT)
            |-> o_needs_fill && (o_new_count == 8'd1))
        else $error("miss without fill or count one");

    // Only an allocating miss asks for a fill.
    a_fill_only_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_needs_fill
            |-> (o_status == bbc_pkg::STAT_NEW || o_status == bbc_pkg::STAT_EVICT))
        else $error("fill requested without a miss");

    // A failed get reports a zero index and count and no fill.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == bbc_pkg::STAT_NONE)
            |-> (o_granted_index == '0) && (o_new_count == '0) && !o_needs_fill)
        else $error("no-buffer response not cleared");

endmodule

bind block_buffer_cache_tags bbc_checker u_bbc_checker (.*);

@@ tb/tb_block_buffer_cache_tags.sv @@
`timescale 1ns / 1ps

module tb_block_buffer_cache_tags;

    localparam int NUM_BUFFERS = bbc_pkg::DEFAULT_BUFFER_COUNT;
    localparam logic [bbc_pkg::ACT_W-1:0] ACT_UNKNOWN = 2'd3;
    localparam int ITEM_TARGET = 1600;
    localparam int TAIL_CYCLES = NUM_BUFFERS + 24;
    localparam int SHOWN_MISMATCHES = 40;

    // Tracks the cache tags and reference counts, and the responses they imply.
    class cache_tag_scoreboard;
        int unsigned               buffers;
        bit                        used [NUM_BUFFERS];
        logic [bbc_pkg::DEV_W-1:0] tag_dev [NUM_BUFFERS];
        logic [bbc_pkg::BLK_W-1:0] tag_blk [NUM_BUFFERS];
        logic [bbc_pkg::CNT_W-1:0] refs [NUM_BUFFERS];
        bbc_pkg::t_result          awaited_responses [$];
        int unsigned               errors;
        int unsigned               responses;
        int unsigned               status_tally [5];

        function new(int unsigned n);
            buffers = n;
            errors = 0;
            responses = 0;
            foreach (used[i]) begin
                used[i] = 1'b0;
                tag_dev[i] = '0;
                tag_blk[i] = '0;
                refs[i] = '0;
            end
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_responses.size();
        endfunction

        task log_mismatch(string msg);
            errors++;
            if (errors <= SHOWN_MISMATCHES) $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Apply one request to the tracked state and return the response it implies.
        function bbc_pkg::t_result lookup_and_count(bbc_pkg::t_req req);
            bbc_pkg::t_result res;
            int               hit;
            int               unused;
            int               zero;
            res = '0;
            res.granted_index = req.buffer_index;
            if (req.action == bbc_pkg::ACT_GET) begin
                hit = -1;
                unused = -1;
                zero = -1;
                for (int i = 0; i < buffers; i++) begin
                    if (used[i]) begin
                        if (hit < 0 && tag_dev[i] == req.device
                                && tag_blk[i] == req.block_number) hit = i;
                        if (zero < 0 && refs[i] == '0) zero = i;
                    end else if (unused < 0) begin
                        unused = i;
                    end
                end
                if (hit >= 0) begin
                    res.granted_index = bbc_pkg::t_idx'(hit);
                    if (refs[hit] == bbc_pkg::CNT_MAX) begin
                        res.status = bbc_pkg::STAT_ERR;
                        res.new_count = bbc_pkg::CNT_MAX;
                    end else begin
                        refs[hit]++;
                        res.status = bbc_pkg::STAT_HIT;
                        res.new_count = refs[hit];
                    end
                end else if (unused >= 0 || zero >= 0) begin
                    // A never-used buffer is preferred over evicting an idle one.
                    hit = (unused >= 0) ? unused : zero;
                    used[hit] = 1'b1;
                    tag_dev[hit] = req.device;
                    tag_blk[hit] = req.block_number;
                    refs[hit] = 1;
                    res.status = (unused >= 0) ? bbc_pkg::STAT_NEW : bbc_pkg::STAT_EVICT;
                    res.granted_index = bbc_pkg::t_idx'(hit);
                    res.needs_fill = 1'b1;
                    res.new_count = 1;
                end else begin
                    res.status = bbc_pkg::STAT_NONE;
                    res.granted_index = '0;
                end
            end else if (req.buffer_index >= buffers) begin
                res.status = bbc_pkg::STAT_ERR;
            end else if (req.action == bbc_pkg::ACT_RELEASE) begin
                if (refs[req.buffer_index] == '0) begin
                    res.status = bbc_pkg::STAT_ERR;
                end else begin
                    refs[req.buffer_index]--;
                    res.status = bbc_pkg::STAT_HIT;
                    res.new_count = refs[req.buffer_index];
                end
            end else if (req.action == bbc_pkg::ACT_PIN) begin
                if (refs[req.buffer_index] == bbc_pkg::CNT_MAX) begin
                    res.status = bbc_pkg::STAT_ERR;
                    res.new_count = bbc_pkg::CNT_MAX;
                end else begin
                    refs[req.buffer_index]++;
                    res.status = bbc_pkg::STAT_HIT;
                    res.new_count = refs[req.buffer_index];
                end
            end else begin
                res.status = bbc_pkg::STAT_ERR;
                res.new_count = refs[req.buffer_index];
            end
            return res;
        endfunction

        function void note_request(bbc_pkg::t_req req);
            awaited_responses.push_back(lookup_and_count(req));
        endfunction

        task check_response(logic [bbc_pkg::STAT_W-1:0] status, bbc_pkg::t_idx index,
                            logic fill, logic [bbc_pkg::CNT_W-1:0] count);
            bbc_pkg::t_result want;
            responses++;
            if (awaited_responses.size() == 0) begin
                log_mismatch($sformatf("response %0d arrived with no request outstanding",
                                       responses));
                return;
            end
            want = awaited_responses.pop_front();
            if (want.status < 5) status_tally[want.status]++;
            if (status !== want.status)
                log_mismatch($sformatf("response %0d: status %0d, expected %0d",
                                       responses, status, want.status));
            if (index !== want.granted_index)
                log_mismatch($sformatf("response %0d: granted index %0d, expected %0d",
                                       responses, index, want.granted_index));
            if (fill !== want.needs_fill)
                log_mismatch($sformatf("response %0d: needs fill %b, expected %b",
                                       responses, fill, want.needs_fill));
            if (count !== want.new_count)
                log_mismatch($sformatf("response %0d: new count %0d, expected %0d",
                                       responses, count, want.new_count));
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [bbc_pkg::ACT_W-1:0]   i_action;
    logic [bbc_pkg::DEV_W-1:0]   i_device;
    logic [bbc_pkg::BLK_W-1:0]   i_block_number;
    logic [bbc_pkg::IDX_W-1:0]   i_buffer_index;
    logic                        o_valid;
    logic                        i_ready;
    logic [bbc_pkg::STAT_W-1:0]  o_status;
    logic [bbc_pkg::IDX_W-1:0]   o_granted_index;
    logic                        o_needs_fill;
    logic [bbc_pkg::CNT_W-1:0]   o_new_count;

    cache_tag_scoreboard sb = new(NUM_BUFFERS);
    int unsigned         items_sent = 0;
    bit                  back_to_back = 1'b0;
    bit                  ceiling_reached = 1'b0;

    block_buffer_cache_tags #(
        .BUFFER_COUNT(NUM_BUFFERS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_device       (i_device),
        .i_block_number (i_block_number),
        .i_buffer_index (i_buffer_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_granted_index(o_granted_index),
        .o_needs_fill   (o_needs_fill),
        .o_new_count    (o_new_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the engine hangs.
    initial begin
        #20_000_000;
        $display("tb_block_buffer_cache_tags: FAIL");
        $finish;
    end

    // Response side: stretches of steady ready, short stalls and occasional long ones.
    initial begin : ready_driver
        int unsigned pick;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                i_ready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge i_clk);
            end else if (pick < 9) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
    end

    // Check every response transaction as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_response(o_status, o_granted_index, o_needs_fill, o_new_count);
    end

    function automatic int unsigned sender_gap();
        int unsigned pick;
        if (back_to_back) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 4);
        if (pick < 98) return $urandom_range(5, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic bbc_pkg::t_req get_request(logic [bbc_pkg::DEV_W-1:0] dev,
                                                  logic [bbc_pkg::BLK_W-1:0] blk);
        bbc_pkg::t_req req;
        req.action = bbc_pkg::ACT_GET;
        req.device = dev;
        req.block_number = blk;
        req.buffer_index = bbc_pkg::t_idx'($urandom);
        return req;
    endfunction

    function automatic bbc_pkg::t_req count_request(logic [bbc_pkg::ACT_W-1:0] act,
                                                    bbc_pkg::t_idx index);
        bbc_pkg::t_req req;
        req.action = act;
        req.device = bbc_pkg::DEV_W'($urandom);
        req.block_number = $urandom;
        req.buffer_index = index;
        return req;
    endfunction

    // A buffer that has been allocated, searched from a random start.
    function automatic int allocated_buffer();
        int unsigned start;
        int unsigned j;
        start = $urandom_range(0, NUM_BUFFERS - 1);
        for (int i = 0; i < NUM_BUFFERS; i++) begin
            j = (start + i) % NUM_BUFFERS;
            if (sb.used[j]) return j;
        end
        return -1;
    endfunction

    // Releases mostly target buffers that still hold references.
    function automatic bbc_pkg::t_idx release_target();
        int unsigned start;
        int unsigned j;
        if ($urandom_range(0, 9) < 7) begin
            start = $urandom_range(0, NUM_BUFFERS - 1);
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                j = (start + i) % NUM_BUFFERS;
                if (sb.refs[j] != '0) return bbc_pkg::t_idx'(j);
            end
        end
        return bbc_pkg::t_idx'($urandom);
    endfunction

    // Gets reuse live tags or draw from a small pool so that hits and evictions are common.
    function automatic bbc_pkg::t_req random_get();
        int unsigned pick;
        int          slot;
        pick = $urandom_range(0, 99);
        slot = allocated_buffer();
        if (pick < 20 && slot >= 0) return get_request(sb.tag_dev[slot], sb.tag_blk[slot]);
        if (pick < 90)
            return get_request(bbc_pkg::DEV_W'($urandom_range(0, 1)), $urandom_range(0, 23));
        return get_request(bbc_pkg::DEV_W'($urandom), $urandom);
    endfunction

    task automatic send_request(input bbc_pkg::t_req req);
        int unsigned gap;
        i_valid <= 1'b1;
        i_action <= req.action;
        i_device <= req.device;
        i_block_number <= req.block_number;
        i_buffer_index <= req.buffer_index;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(req);
        items_sent++;
        gap = sender_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_responses();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Corner cases from reset: empty counts, never-used buffers, field extremes.
    task automatic run_directed();
        send_request(count_request(bbc_pkg::ACT_RELEASE, 5'd0));
        send_request(count_request(ACT_UNKNOWN, 5'd31));
        send_request(count_request(bbc_pkg::ACT_PIN, 5'd31));
        send_request(count_request(bbc_pkg::ACT_RELEASE, 5'd31));
        send_request(get_request('0, '0));
        send_request(get_request('1, '1));
        send_request(get_request('0, '0));
        send_request(get_request('0, '1));
        send_request(get_request('1, '0));
        send_request(get_request(16'hAAAA, 32'h5555_5555));
        send_request(get_request(16'h5555, 32'hAAAA_AAAA));
        send_request(count_request(bbc_pkg::ACT_RELEASE, 5'd0));
        send_request(count_request(bbc_pkg::ACT_RELEASE, 5'd0));
        send_request(count_request(bbc_pkg::ACT_RELEASE, 5'd0));
        send_request(count_request(bbc_pkg::ACT_PIN, 5'd1));
        send_request(count_request(ACT_UNKNOWN, 5'd1));
        send_request(get_request('1, '1));
        send_request(count_request(ACT_UNKNOWN, 5'd20));
    endtask

    // Drive one buffer to the count ceiling, poke it there, then release it fully.
    task automatic saturate_one_buffer();
        int            slot;
        bbc_pkg::t_idx target;
        slot = allocated_buffer();
        target = (slot >= 0) ? bbc_pkg::t_idx'(slot) : bbc_pkg::t_idx'($urandom);
        while (sb.refs[target] != bbc_pkg::CNT_MAX)
            send_request(count_request(bbc_pkg::ACT_PIN, target));
        ceiling_reached = 1'b1;
        send_request(count_request(bbc_pkg::ACT_PIN, target));
        if (sb.used[target])
            send_request(get_request(sb.tag_dev[target], sb.tag_blk[target]));
        send_request(count_request(ACT_UNKNOWN, target));
        while (sb.refs[target] != '0)
            send_request(count_request(bbc_pkg::ACT_RELEASE, target));
        send_request(count_request(bbc_pkg::ACT_RELEASE, target));
    endtask

    // Randomly mixed fill-heavy and release-heavy bursts keep the cache cycling
    // between free buffers, evictions and refusals, and one pass saturates a buffer.
    task automatic run_random();
        int unsigned kind;
        int unsigned burst;
        int unsigned get_w;
        int unsigned rel_w;
        int unsigned pick;
        bit          saturated;
        saturated = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            back_to_back = ($urandom_range(0, 9) < 3);
            if (!saturated && items_sent > 500) begin
                drain_responses();
                saturate_one_buffer();
                saturated = 1'b1;
            end else begin
                kind = $urandom_range(0, 9);
                burst = $urandom_range(15, 70);
                if (kind < 5) begin
                    get_w = 60;
                    rel_w = $urandom_range(5, 30);
                end else begin
                    get_w = 25;
                    rel_w = 65;
                end
                repeat (burst) begin
                    pick = $urandom_range(0, get_w + rel_w + 10);
                    if (pick < get_w)
                        send_request(random_get());
                    else if (pick < get_w + rel_w)
                        send_request(count_request(bbc_pkg::ACT_RELEASE, release_target()));
                    else if (pick < get_w + rel_w + 8)
                        send_request(count_request(bbc_pkg::ACT_PIN,
                                                   bbc_pkg::t_idx'($urandom)));
                    else
                        send_request(count_request(ACT_UNKNOWN, bbc_pkg::t_idx'($urandom)));
                end
            end
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_action <= bbc_pkg::ACT_GET;
        i_device <= '0;
        i_block_number <= '0;
        i_buffer_index <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();
        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.outstanding() != 0)
            sb.log_mismatch($sformatf("%0d responses never arrived", sb.outstanding()));

        $display("Covered %0d request transactions: %0d hits or count updates,",
                 items_sent, sb.status_tally[bbc_pkg::STAT_HIT]);
        $display("%0d new buffers, %0d evictions, %0d refusals, %0d count errors; ceiling: %0d.",
                 sb.status_tally[bbc_pkg::STAT_NEW], sb.status_tally[bbc_pkg::STAT_EVICT],
                 sb.status_tally[bbc_pkg::STAT_NONE], sb.status_tally[bbc_pkg::STAT_ERR],
                 ceiling_reached);
        if (sb.errors == 0) begin
            $display("tb_block_buffer_cache_tags: PASS");
        end else begin
            $display("tb_block_buffer_cache_tags: FAIL");
        end
        $finish;
    end

endmodule
